/* rtl/cvkf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cvkf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 64;
  localparam int DIV_STEPS = 64;

  localparam logic [19:0] STEP_TIME_RST     = 20'd4369;
  localparam logic [30:0] PROC_VAR_RST      = 31'd2359296;
  localparam logic [30:0] MEAS_VAR_RST      = 31'd262144;
  localparam logic [31:0] COV_INIT          = 32'sd10 <<< FRAC_BITS;

  localparam logic [1:0] MODE_INIT    = 2'd0;
  localparam logic [1:0] MODE_PREDICT = 2'd1;
  localparam logic [1:0] MODE_UPDATE  = 2'd2;
  localparam logic [1:0] MODE_HOLD    = 2'd3;

  localparam logic [1:0] REG_STEP_TIME = 2'd0;
  localparam logic [1:0] REG_PROC_VAR  = 2'd1;
  localparam logic [1:0] REG_MEAS_VAR  = 2'd2;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Add two saturated 32-bit values with saturation.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b);
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [65:0] s;
    s = 66'(a) - 66'(b);
    return sat32(s);
  endfunction

endpackage
`default_nettype wire

/* rtl/constant_velocity_kalman_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Init and mode three go straight to the result; predict runs eight multiplies on one
// shared multiplier; update runs two 64-step restoring divisions plus six multiplies,
// and skips the divisions when S is zero.
// Throughput: one item at a time; in_stall is high from acceptance until the
// result transfer completes, and the next item is taken the cycle after that.
// Sync active-high reset zeroes estimates/covariances and loads register defaults.
module constant_velocity_kalman_filter
  import cvkf_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [3:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [1:0]        mode,
  input  wire signed [31:0] measurement,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [31:0] position,
  output logic signed [31:0] velocity
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_SEQ  = 7'b0001000,
    S_MULW = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_DIVW = 7'b1000000
  } state_t;

  state_t state;

  logic [19:0] step_time;
  logic [30:0] process_variance;
  logic [30:0] measurement_variance;

  logic signed [31:0] pos_est, vel_est, pri_pos, pri_vel;
  logic signed [31:0] post_cov [4];
  logic signed [31:0] pri_cov  [4];

  logic [1:0]          mode_r;
  logic signed [31:0]  z_r;
  logic [4:0]          step;
  logic signed [31:0]  tmp [6];

  // Config port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= STEP_TIME_RST;
      process_variance <= PROC_VAR_RST;
      measurement_variance <= MEAS_VAR_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_STEP_TIME: step_time <= pwdata[19:0];
        REG_PROC_VAR:  process_variance <= pwdata[30:0];
        REG_MEAS_VAR:  measurement_variance <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STEP_TIME: prdata = {12'd0, step_time};
      REG_PROC_VAR:  prdata = {1'b0, process_variance};
      REG_MEAS_VAR:  prdata = {1'b0, measurement_variance};
      default:       prdata = '0;
    endcase
  end

  // Shared multiplier: registered operands, registered rounded result
  logic signed [31:0] ma, mb;
  logic signed [63:0] mprod;
  logic signed [31:0] mres;
  logic signed [63:0] mrnd;
  assign mprod = ma * mb;
  assign mrnd  = (mprod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  always_ff @(posedge clk) begin
    mres <= sat32(66'(mrnd));
  end

  // Shared restoring divider for |num|*2^F / |den|
  logic [63:0] dquo;
  logic [63:0] drem_w;
  logic [31:0] dden;
  logic [31:0] drem;
  logic [5:0]  dcnt;
  logic        dneg;
  logic [32:0] dtrial;
  assign dtrial = {drem, dquo[63]} - {1'b0, dden};
  logic signed [31:0] dres;
  always_comb begin
    logic signed [65:0] v;
    v = dneg ? -$signed({2'b0, dquo}) : $signed({2'b0, dquo});
    dres = sat32(v);
  end
  assign drem_w = dquo;

  // Gain numerator: p00 for the first division, p10 for the second
  logic signed [31:0] div_num;
  assign div_num = (step == 5'd1) ? pri_cov[0] : pri_cov[2];

  // Operand selection helpers
  logic signed [31:0] dt_s, q_s;
  assign dt_s = $signed({12'd0, step_time});
  assign q_s  = $signed({1'b0, process_variance});

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos_est <= '0; vel_est <= '0; pri_pos <= '0; pri_vel <= '0;
      for (int i = 0; i < 4; i++) begin
        post_cov[i] <= '0;
        pri_cov[i] <= '0;
      end
      step <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= mode;
            z_r <= measurement;
            step <= '0;
            if (mode == MODE_INIT) begin
              pos_est <= measurement;
              vel_est <= '0;
              for (int i = 0; i < 4; i++) post_cov[i] <= COV_INIT;
              state <= S_OUT;
            end else if (mode == MODE_PREDICT || mode == MODE_UPDATE) begin
              state <= S_SEQ;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SEQ: begin
          // issue next operation
          state <= S_MUL;
          if (mode_r == MODE_PREDICT) begin
            case (step)
              5'd0: begin ma <= dt_s; mb <= post_cov[2]; end
              5'd1: begin ma <= dt_s; mb <= post_cov[3]; end
              5'd2: begin ma <= dt_s; mb <= q_s; end
              5'd3: begin ma <= dt_s; mb <= dt_s; end
              5'd4: begin ma <= tmp[3]; mb <= q_s; end
              5'd5: begin ma <= dt_s; mb <= vel_est; end
              5'd6: begin ma <= dt_s; mb <= tmp[1]; end
              default: begin ma <= dt_s; mb <= post_cov[3]; end
            endcase
          end else begin
            case (step)
              5'd0: begin
                // S and the innovation z minus prior position for k0
                tmp[0] <= sat_add(pri_cov[0], $signed({1'b0, measurement_variance}));
                tmp[1] <= sat_sub(z_r, pri_pos);
                state <= S_SEQ;
                step <= 5'd1;
              end
              5'd1, 5'd2: begin
                if (tmp[0] == 0) begin
                  if (step == 5'd1) tmp[2] <= '0;
                  else tmp[3] <= '0;
                  state <= S_SEQ;
                  step <= step + 5'd1;
                end else begin
                  dneg <= div_num[31] ^ tmp[0][31];
                  dden <= tmp[0][31] ? 32'(-tmp[0]) : tmp[0];
                  dquo <= {(div_num[31] ? 32'(-div_num) : div_num), 32'd0}
                          >> (32 - FRAC_BITS);
                  drem <= '0;
                  dcnt <= '0;
                  state <= S_DIV;
                end
              end
              5'd3: begin ma <= tmp[2]; mb <= tmp[1]; end
              5'd4: begin ma <= tmp[3]; mb <= tmp[1]; end
              5'd5: begin ma <= tmp[2]; mb <= pri_cov[0]; end
              5'd6: begin ma <= tmp[2]; mb <= pri_cov[1]; end
              5'd7: begin ma <= tmp[3]; mb <= pri_cov[0]; end
              default: begin ma <= tmp[3]; mb <= pri_cov[1]; end
            endcase
          end
        end
        S_DIV: begin
          if (dtrial[32]) begin
            drem <= {drem[30:0], dquo[63]};
            dquo <= {drem_w[62:0], 1'b0};
          end else begin
            drem <= dtrial[31:0];
            dquo <= {drem_w[62:0], 1'b1};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(DIV_STEPS - 1)) state <= S_DIVW;
        end
        S_DIVW: begin
          if (step == 5'd1) tmp[2] <= dres;
          else tmp[3] <= dres;
          step <= step + 5'd1;
          state <= S_SEQ;
        end
        S_MUL: state <= S_MULW;
        S_MULW: begin
          state <= S_SEQ;
          step <= step + 5'd1;
          if (mode_r == MODE_PREDICT) begin
            case (step)
              5'd0: tmp[0] <= sat_add(post_cov[0], mres);
              5'd1: tmp[1] <= sat_add(post_cov[1], mres);
              5'd2: tmp[2] <= mres;
              5'd3: tmp[3] <= mres;
              5'd4: tmp[4] <= mres;
              5'd5: tmp[5] <= sat_add(pos_est, mres);
              5'd6: tmp[0] <= sat_add(tmp[0], mres);
              default: begin
                pri_cov[0] <= sat_add(tmp[0], tmp[4]);
                pri_cov[1] <= sat_add(tmp[1], tmp[2]);
                pri_cov[2] <= sat_add(sat_add(post_cov[2], mres), tmp[2]);
                pri_cov[3] <= sat_add(post_cov[3], q_s);
                post_cov[0] <= sat_add(tmp[0], tmp[4]);
                post_cov[1] <= sat_add(tmp[1], tmp[2]);
                post_cov[2] <= sat_add(sat_add(post_cov[2], mres), tmp[2]);
                post_cov[3] <= sat_add(post_cov[3], q_s);
                pri_pos <= tmp[5]; pri_vel <= vel_est;
                pos_est <= tmp[5];
                state <= S_OUT;
              end
            endcase
          end else begin
            case (step)
              5'd3: pos_est <= sat_add(pri_pos, mres);
              5'd4: vel_est <= sat_add(pri_vel, mres);
              5'd5: post_cov[0] <= sat_sub(pri_cov[0], mres);
              5'd6: post_cov[1] <= sat_sub(pri_cov[1], mres);
              5'd7: post_cov[2] <= sat_sub(pri_cov[2], mres);
              default: begin
                post_cov[3] <= sat_sub(pri_cov[3], mres);
                state <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign position = pos_est;
  assign velocity = vel_est;

  // Result is offered only while no item is being taken.
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result offered while accepting");
  // A completed result transfer returns the block to accepting items.
  a_out_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !in_stall) else $error("no return to idle");
  // Output estimate holds while the result waits.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(position) && $stable(velocity))
    else $error("result changed while stalled");

endmodule
`default_nettype wire
